// File: design/bus_session_master_fsm_assert.svh
// Assertion macros shared by the session controller RTL
`ifndef BUS_SESSION_MASTER_FSM_ASSERT_SVH
`define BUS_SESSION_MASTER_FSM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BSM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsm assertion failed");

// next-cycle implication, disabled during reset
`define BSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsm assertion failed");

`endif

// File: design/bsm_pkg.sv
// Types, codes and defaults for the bus session master controller
`default_nettype none

package bsm_pkg;

    localparam int INIT_INTERVAL_DEF = 128;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int PHASE_W           = 4;
    localparam int ACTION_W          = 3;

    // phase codes
    localparam logic [PHASE_W-1:0] ST_INIT     = 4'd0;
    localparam logic [PHASE_W-1:0] ST_CONNECT  = 4'd1;
    localparam logic [PHASE_W-1:0] ST_START    = 4'd2;
    localparam logic [PHASE_W-1:0] ST_SESS_REQ = 4'd3;
    localparam logic [PHASE_W-1:0] ST_SESS_RSP = 4'd4;
    localparam logic [PHASE_W-1:0] ST_IDLE     = 4'd5;
    localparam logic [PHASE_W-1:0] ST_DATA_REQ = 4'd6;
    localparam logic [PHASE_W-1:0] ST_DATA_RSP = 4'd7;
    localparam logic [PHASE_W-1:0] ST_ERROR    = 4'd8;
    localparam logic [PHASE_W-1:0] ST_TIMEOUT  = 4'd9;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CONNECT   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_START_SYM = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SESS_REQ  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SESS_POLL = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DATA_REQ  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_DATA_POLL = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_SEQ_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SEQ_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECV_WAIT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIOD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_HOLD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_HOLD     = 3'd5;

    // register reset values
    localparam logic [15:0] START_SEQ_PERIOD_RST = 16'd5;
    localparam logic [7:0]  START_SEQ_LENGTH_RST = 8'd8;
    localparam logic [15:0] RECV_WAIT_RST        = 16'd2000;
    localparam logic [15:0] IDLE_PERIOD_RST      = 16'd1000;
    localparam logic [15:0] ERROR_HOLD_RST       = 16'd5000;
    localparam logic [15:0] TIMEOUT_HOLD_RST     = 16'd15000;

    typedef struct packed {
        logic op_failed;
        logic rsp_complete;
    } in_word_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                bus_reset;
        logic                bus_timeout;
        logic [PHASE_W-1:0]  fsm_state;
    } out_word_t;

    typedef struct packed {
        logic [15:0] start_seq_period;
        logic [7:0]  start_seq_length;
        logic [15:0] recv_wait;
        logic [15:0] idle_period;
        logic [15:0] error_hold;
        logic [15:0] timeout_hold;
    } cfg_t;

endpackage

`default_nettype wire

// File: design/bsm_core.sv
// Session state machine: phase, shared timer and counters, one step per word
`default_nettype none

`include "bus_session_master_fsm_assert.svh"

module bsm_core #(
    parameter int INIT_INTERVAL = bsm_pkg::INIT_INTERVAL_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bsm_pkg::cfg_t     cfg,
    input  wire logic              step,
    input  wire bsm_pkg::in_word_t in_word,
    output bsm_pkg::out_word_t     out_word
);
    import bsm_pkg::*;

    localparam int TICK_W = $clog2(INIT_INTERVAL);
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(INIT_INTERVAL - 1);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [7:0]         start_reg, start_next;
    logic [15:0]        wait_reg, wait_next;
    logic [15:0]        wait_inc;
    logic [15:0]        period;
    logic               expired;

    assign wait_inc = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;
    assign tick_next = (tick_reg == TICK_LAST) ? '0 : tick_reg + TICK_W'(1);

    always_comb begin
        case (phase_reg)
            ST_START:                 period = cfg.start_seq_period;
            ST_SESS_RSP, ST_DATA_RSP: period = cfg.recv_wait;
            ST_IDLE:                  period = cfg.idle_period;
            ST_ERROR:                 period = cfg.error_hold;
            default:                  period = cfg.timeout_hold;
        endcase
    end

    assign expired = (wait_inc >= period);

    always_comb begin
        phase_next = phase_reg;
        start_next = start_reg;
        wait_next  = wait_reg;
        out_word   = '0;
        unique case (phase_reg)
            ST_INIT: begin
                if (tick_reg == '0) begin
                    phase_next = ST_CONNECT;
                end
            end
            ST_CONNECT: begin
                out_word.action = ACT_CONNECT;
                wait_next = '0;
                if (in_word.op_failed) begin
                    out_word.bus_reset = 1'b1;
                    phase_next = ST_ERROR;
                end else begin
                    start_next = '0;
                    phase_next = ST_START;
                end
            end
            ST_START: begin
                wait_next = wait_inc;
                if (expired) begin
                    out_word.action = ACT_START_SYM;
                    if (in_word.op_failed) begin
                        out_word.bus_reset = 1'b1;
                        wait_next = '0;
                        phase_next = ST_ERROR;
                    end else if (start_reg >= cfg.start_seq_length) begin
                        phase_next = ST_SESS_REQ;
                    end else begin
                        wait_next = '0;
                        start_next = start_reg + 8'd1;
                    end
                end
            end
            ST_SESS_REQ, ST_DATA_REQ: begin
                out_word.action = (phase_reg == ST_SESS_REQ) ? ACT_SESS_REQ : ACT_DATA_REQ;
                wait_next = '0;
                if (in_word.op_failed) begin
                    out_word.bus_reset = 1'b1;
                    phase_next = ST_ERROR;
                end else begin
                    phase_next = (phase_reg == ST_SESS_REQ) ? ST_SESS_RSP : ST_DATA_RSP;
                end
            end
            ST_SESS_RSP, ST_DATA_RSP: begin
                out_word.action = (phase_reg == ST_SESS_RSP) ? ACT_SESS_POLL : ACT_DATA_POLL;
                if (in_word.op_failed) begin
                    out_word.bus_reset = 1'b1;
                    wait_next = '0;
                    phase_next = ST_ERROR;
                end else if (expired) begin
                    out_word.bus_timeout = 1'b1;
                    wait_next = '0;
                    phase_next = ST_TIMEOUT;
                end else begin
                    wait_next = wait_inc;
                    if (in_word.rsp_complete) begin
                        if (phase_reg == ST_SESS_RSP) begin
                            phase_next = ST_DATA_REQ;
                        end else begin
                            wait_next = '0;
                            phase_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_IDLE: begin
                wait_next = wait_inc;
                if (expired) begin
                    phase_next = ST_DATA_REQ;
                end
            end
            ST_ERROR: begin
                wait_next = wait_inc;
                if (expired) begin
                    phase_next = ST_INIT;
                end
            end
            ST_TIMEOUT: begin
                wait_next = wait_inc;
                if (expired) begin
                    wait_next = '0;
                    start_next = '0;
                    phase_next = ST_START;
                end
            end
            default: begin
                phase_next = ST_INIT;
            end
        endcase
        out_word.fsm_state = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ST_INIT;
            tick_reg  <= '0;
            start_reg <= '0;
            wait_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            start_reg <= start_next;
            wait_reg  <= wait_next;
        end
    end

    `BSM_ASSERT_NEXT(a_reset_to_error, aclk, aresetn,
        step && out_word.bus_reset, phase_reg == ST_ERROR && wait_reg == '0)
    `BSM_ASSERT_NEXT(a_timeout_entry, aclk, aresetn,
        step && out_word.bus_timeout, phase_reg == ST_TIMEOUT && wait_reg == '0)
    `BSM_ASSERT_NEXT(a_hold_without_step, aclk, aresetn,
        !step, $stable(phase_reg) && $stable(wait_reg) && $stable(tick_reg))
    `BSM_ASSERT_NEXT(a_init_waits_tick, aclk, aresetn,
        step && phase_reg == ST_INIT && tick_reg != '0, phase_reg == ST_INIT)

endmodule

`default_nettype wire

// File: design/bus_session_master_fsm.sv
// Path: a word accepted on s_ goes through the input register, then the result register, to m_.
// Throughput: one word per cycle unless m_ready stalls; one pass of state logic per word.
// Stalls on m_ready back up through the result register into s_ready.
// Reset (aresetn low at a clock edge): phase init, counters zero, registers at defaults,
// both channels empty.
`default_nettype none

`include "bus_session_master_fsm_assert.svh"

module bus_session_master_fsm #(
    parameter int INIT_INTERVAL = bsm_pkg::INIT_INTERVAL_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bsm_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire bsm_pkg::in_word_t              s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output bsm_pkg::out_word_t                  m_data
);
    import bsm_pkg::*;

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t res_word;
    logic      out_free;
    logic      step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_seq_period <= START_SEQ_PERIOD_RST;
            cfg_reg.start_seq_length <= START_SEQ_LENGTH_RST;
            cfg_reg.recv_wait        <= RECV_WAIT_RST;
            cfg_reg.idle_period      <= IDLE_PERIOD_RST;
            cfg_reg.error_hold       <= ERROR_HOLD_RST;
            cfg_reg.timeout_hold     <= TIMEOUT_HOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_START_SEQ_PERIOD: cfg_reg.start_seq_period <= cfg_wr_data;
                REG_START_SEQ_LENGTH: cfg_reg.start_seq_length <= cfg_wr_data[7:0];
                REG_RECV_WAIT:        cfg_reg.recv_wait        <= cfg_wr_data;
                REG_IDLE_PERIOD:      cfg_reg.idle_period      <= cfg_wr_data;
                REG_ERROR_HOLD:       cfg_reg.error_hold       <= cfg_wr_data;
                REG_TIMEOUT_HOLD:     cfg_reg.timeout_hold     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
    end

    bsm_core #(
        .INIT_INTERVAL(INIT_INTERVAL)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .step     (step),
        .in_word  (in_word_reg),
        .out_word (res_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_word_reg <= res_word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    `BSM_ASSERT_NEXT(a_step_fills_output, aclk, aresetn, step, out_valid_reg)
    `BSM_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_ready, !s_ready && !step)
    `BSM_ASSERT_NEXT(a_accept_loads_input, aclk, aresetn, s_valid && s_ready, in_valid_reg)

endmodule

`default_nettype wire

// File: verif/bus_session_master_fsm_chk.sv
// Scoreboard for the session controller: predicts each result word and compares it
`timescale 1ns / 1ps

module bus_session_master_fsm_chk
    import bsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_word_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_word_t             m_data,
    output int                    fail_count,
    output int                    backlog,
    output int                    checked,
    output int                    timeouts,
    output int                    resets,
    output logic [9:0]            states_seen
);

    logic [15:0] period_q;
    logic [7:0]  len_q;
    logic [15:0] recv_q;
    logic [15:0] idle_q;
    logic [15:0] errh_q;
    logic [15:0] tmoh_q;

    logic [PHASE_W-1:0] ph;
    int                 ticks;
    logic [7:0]         sym_cnt;
    logic [15:0]        timer;

    out_word_t   session_q[$];
    int          fails;
    int          n_checked;
    int          n_timeouts;
    int          n_resets;
    logic [9:0]  seen;

    function automatic bit timer_up(logic [15:0] lim);
        if (timer != 16'hFFFF) timer++;
        return timer >= lim;
    endfunction

    function automatic void fault();
        timer = '0;
        ph    = ST_ERROR;
    endfunction

    function automatic void restart();
        sym_cnt = '0;
        timer   = '0;
        ph      = ST_START;
    endfunction

    function automatic out_word_t next_word(in_word_t w);
        out_word_t          o;
        logic [PHASE_W-1:0] prev;
        o      = '0;
        prev   = ph;
        o.action = ACT_NONE;
        case (ph)
            ST_INIT: begin
                if (ticks == 0) ph = ST_CONNECT;
            end
            ST_CONNECT: begin
                o.action = ACT_CONNECT;
                if (w.op_failed) fault();
                else restart();
            end
            ST_START: begin
                if (timer_up(period_q)) begin
                    o.action = ACT_START_SYM;
                    if (w.op_failed) begin
                        fault();
                    end else if (sym_cnt >= len_q) begin
                        ph = ST_SESS_REQ;
                    end else begin
                        timer = '0;
                        sym_cnt++;
                    end
                end
            end
            ST_SESS_REQ, ST_DATA_REQ: begin
                o.action = (ph == ST_SESS_REQ) ? ACT_SESS_REQ : ACT_DATA_REQ;
                if (w.op_failed) begin
                    fault();
                end else begin
                    timer = '0;
                    ph = (ph == ST_SESS_REQ) ? ST_SESS_RSP : ST_DATA_RSP;
                end
            end
            ST_SESS_RSP, ST_DATA_RSP: begin
                o.action = (ph == ST_SESS_RSP) ? ACT_SESS_POLL : ACT_DATA_POLL;
                if (w.op_failed) begin
                    fault();
                end else if (timer_up(recv_q)) begin
                    o.bus_timeout = 1'b1;
                    timer = '0;
                    ph = ST_TIMEOUT;
                end else if (w.rsp_complete) begin
                    if (ph == ST_SESS_RSP) begin
                        ph = ST_DATA_REQ;
                    end else begin
                        timer = '0;
                        ph = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (timer_up(idle_q)) ph = ST_DATA_REQ;
            end
            ST_ERROR: begin
                if (timer_up(errh_q)) ph = ST_INIT;
            end
            ST_TIMEOUT: begin
                if (timer_up(tmoh_q)) restart();
            end
            default: begin
                ph = ST_INIT;
            end
        endcase
        // error is only ever entered through a failed operation
        o.bus_reset = (ph == ST_ERROR) && (prev != ST_ERROR);
        ticks = (ticks + 1) % INIT_INTERVAL_DEF;
        o.fsm_state = ph;
        return o;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            period_q = START_SEQ_PERIOD_RST;
            len_q    = START_SEQ_LENGTH_RST;
            recv_q   = RECV_WAIT_RST;
            idle_q   = IDLE_PERIOD_RST;
            errh_q   = ERROR_HOLD_RST;
            tmoh_q   = TIMEOUT_HOLD_RST;
            ph       = ST_INIT;
            ticks    = 0;
            sym_cnt  = '0;
            timer    = '0;
            session_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_SEQ_PERIOD: period_q = cfg_wr_data;
                    REG_START_SEQ_LENGTH: len_q    = cfg_wr_data[7:0];
                    REG_RECV_WAIT:        recv_q   = cfg_wr_data;
                    REG_IDLE_PERIOD:      idle_q   = cfg_wr_data;
                    REG_ERROR_HOLD:       errh_q   = cfg_wr_data;
                    REG_TIMEOUT_HOLD:     tmoh_q   = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) session_q.push_back(next_word(s_data));
            if (m_valid && m_ready) begin
                if (session_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word: action %0d reset %b timeout %b state %0d",
                                 m_data.action, m_data.bus_reset, m_data.bus_timeout,
                                 m_data.fsm_state);
                end else begin
                    want = session_q.pop_front();
                    n_checked++;
                    if (want.bus_timeout) n_timeouts++;
                    if (want.bus_reset) n_resets++;
                    if (want.fsm_state < 10) seen[want.fsm_state] = 1'b1;
                    if (m_data.action !== want.action || m_data.bus_reset !== want.bus_reset ||
                        m_data.bus_timeout !== want.bus_timeout ||
                        m_data.fsm_state !== want.fsm_state) begin
                        fails++;
                        if (fails <= 10)
                            $display("word %0d: expected action %0d reset %b timeout %b state %0d, got action %0d reset %b timeout %b state %0d",
                                     n_checked, want.action, want.bus_reset, want.bus_timeout,
                                     want.fsm_state, m_data.action, m_data.bus_reset,
                                     m_data.bus_timeout, m_data.fsm_state);
                    end
                end
            end
        end
        fail_count  <= fails;
        backlog     <= session_q.size();
        checked     <= n_checked;
        timeouts    <= n_timeouts;
        resets      <= n_resets;
        states_seen <= seen;
    end

    initial begin
        fails      = 0;
        n_checked  = 0;
        n_timeouts = 0;
        n_resets   = 0;
        seen       = '0;
    end

endmodule

// File: verif/bus_session_master_fsm_tb.sv
// Top-level testbench for the session controller: stimulus, register settings and verdict
`timescale 1ns / 1ps

module bus_session_master_fsm_tb;
    import bsm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_word_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b1;
    out_word_t             m_data;

    int         chk_fails;
    int         chk_backlog;
    int         chk_checked;
    int         chk_timeouts;
    int         chk_resets;
    logic [9:0] chk_states;

    bit quiet = 1'b0;
    int words_sent = 0;
    int cfg_sets = 0;

    // boot under defaults, then a hand walk through every state but connect with short timers
    in_word_t boot_words[6] = '{2'b00, 2'b00, 2'b10, 2'b01, 2'b11, 2'b00};
    in_word_t walk_words[21] = '{2'b00, 2'b01, 2'b00, 2'b01, 2'b00, 2'b01, 2'b10,
                                 2'b11, 2'b00, 2'b00, 2'b00, 2'b01, 2'b11, 2'b00,
                                 2'b00, 2'b00, 2'b00, 2'b00, 2'b11, 2'b00, 2'b00};

    bus_session_master_fsm dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    bus_session_master_fsm_chk u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (chk_fails),
        .backlog     (chk_backlog),
        .checked     (chk_checked),
        .timeouts    (chk_timeouts),
        .resets      (chk_resets),
        .states_seen (chk_states)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic push_word(in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // hold off until every predicted word has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chk_backlog != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(logic [15:0] per, logic [7:0] len, logic [15:0] rw,
                             logic [15:0] idle, logic [15:0] eh, logic [15:0] th);
        logic [CFG_IDX_W-1:0]  idx[7];
        logic [CFG_DATA_W-1:0] val[7];
        idx = '{REG_START_SEQ_PERIOD, REG_START_SEQ_LENGTH, REG_RECV_WAIT, REG_IDLE_PERIOD,
                REG_ERROR_HOLD, REG_TIMEOUT_HOLD,
                ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B};
        val = '{per, {8'($urandom), len}, rw, idle, eh, th, 16'($urandom)};
        cfg_wr_en <= 1'b1;
        for (int i = 0; i < 7; i++) begin
            cfg_index   <= idx[i];
            cfg_wr_data <= val[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        cfg_sets++;
    endtask

    task automatic configure_short();
        configure(16'($urandom_range(1, 4)), 8'($urandom_range(0, 6)),
                  16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)));
    endtask

    task automatic run_phase(int words, int fail_pct, int done_pct);
        in_word_t w;
        repeat (words) begin
            w.op_failed    = $urandom_range(0, 99) < fail_pct;
            w.rsp_complete = $urandom_range(0, 99) < done_pct;
            push_word(w);
        end
    endtask

    initial begin
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d words sent, %0d results checked", words_sent, chk_checked);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (boot_words[i]) push_word(boot_words[i]);
        settle();
        configure(16'd1, 8'd1, 16'd3, 16'd2, 16'd2, 16'd3);
        foreach (walk_words[i]) push_word(walk_words[i]);
        settle();

        configure_short();
        run_phase(300, 4, 40);
        settle();
        // zero periods expire on the first tick
        configure(16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(100, 10, 50);
        settle();
        configure(16'd1, 8'd255, 16'($urandom_range(2, 6)), 16'd1, 16'd1, 16'd2);
        run_phase(350, 1, 30);
        settle();
        configure(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(60, 5, 50);
        settle();
        repeat (3) begin
            configure_short();
            run_phase(100, $urandom_range(0, 20), $urandom_range(10, 90));
            settle();
        end

        quiet <= 1'b1;
        configure_short();
        run_phase(150, 3, 40);
        settle();

        $display("sent %0d words across %0d register settings, %0d results checked",
                 words_sent, cfg_sets, chk_checked);
        $display("states reached %b, timeouts %0d, bus resets %0d",
                 chk_states, chk_timeouts, chk_resets);
        if (chk_fails == 0 && chk_backlog == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
